// File: src/assert_macros.svh
// assertion macros shared by the echo ranging and follow steering modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// property must hold at every clock edge out of reset
`define ERFS_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// expression must never be true out of reset
`define ERFS_ASSERT_NEVER(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define ERFS_ASSERT(label, prop, msg)
`define ERFS_ASSERT_NEVER(label, expr, msg)
`endif

`endif

// File: src/erfs_pkg.sv
// types and constants for the echo ranging and follow steering block
package erfs_pkg;

    // item kinds
    localparam logic OP_CAPTURE = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 10;

    localparam logic [CFG_INDEX_W-1:0] REG_FORWARD_DUTY   = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TURN_FAST_DUTY = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_TURN_SLOW_DUTY = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_FOLLOW_NEAR_CM = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FOLLOW_FAR_CM  = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKOFF_CM     = 3'd5;

    // register reset values
    localparam logic [7:0] FORWARD_DUTY_RST   = 8'd120;
    localparam logic [7:0] TURN_FAST_DUTY_RST = 8'd220;
    localparam logic [7:0] TURN_SLOW_DUTY_RST = 8'd70;
    localparam logic [9:0] FOLLOW_NEAR_CM_RST = 10'd8;
    localparam logic [9:0] FOLLOW_FAR_CM_RST  = 10'd30;
    localparam logic [9:0] BACKOFF_CM_RST     = 10'd5;

    // distance saturation
    localparam logic [9:0] CM_MAX = 10'd1023;

    // direction pin levels
    localparam logic LEFT_FWD  = 1'b1;
    localparam logic LEFT_BWD  = 1'b0;
    localparam logic RIGHT_FWD = 1'b0;
    localparam logic RIGHT_BWD = 1'b1;

    typedef struct packed {
        logic        operation;
        logic [15:0] capture_value;
        logic        button_first;
        logic        button_second;
        logic        left_ir_level;
        logic        right_ir_level;
    } in_word_t;

    typedef struct packed {
        logic       left_dir_level;
        logic       right_dir_level;
        logic [7:0] left_duty;
        logic [7:0] right_duty;
        logic [9:0] distance_cm;
        logic       running;
    } out_word_t;

    // classified command passed from front to back
    typedef struct packed {
        logic        operation;
        logic        measure;
        logic [15:0] width;
        logic        button_first;
        logic        button_second;
        logic        left_ir_level;
        logic        right_ir_level;
    } cmd_t;

endpackage

// File: src/erfs_fifo.sv
// small first-in first-out queue of words
`include "assert_macros.svh"

module erfs_fifo #(
    parameter int W     = 8,
    parameter int DEPTH = 2
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  logic [W-1:0] din,
    output logic         full,
    input  logic         pop,
    output logic [W-1:0] dout,
    output logic         empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic [W-1:0]     store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == DEPTH_CNT);
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = store_reg[rd_ptr_reg];

    // pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // word storage
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            store_reg[wr_ptr_reg] <= din;
        end
    end

    `ERFS_ASSERT(a_count_bound, count_reg <= DEPTH_CNT, "fifo count above depth")
    `ERFS_ASSERT(a_push_grows, do_push && !do_pop |=> count_reg == $past(count_reg) + 1'b1, "fifo push lost")
    `ERFS_ASSERT(a_pop_shrinks, do_pop && !do_push |=> count_reg == $past(count_reg) - 1'b1, "fifo pop lost")

endmodule

// File: src/erfs_front.sv
// front end: accepts items, tracks echo edges and forms the pulse width
module erfs_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  erfs_pkg::in_word_t in_word,
    input  logic              cmd_full,
    output logic              cmd_push,
    output erfs_pkg::cmd_t    cmd
);

    logic        expect_rising_reg, expect_rising_next;
    logic [15:0] last_capture_reg, last_capture_next;
    logic        is_capture;

    assign cmd_push   = push && !cmd_full;
    assign is_capture = (in_word.operation == erfs_pkg::OP_CAPTURE);

    // classify the word and take the wrapped width against the stored edge
    always_comb
    begin
        cmd.operation      = in_word.operation;
        cmd.measure        = is_capture && !expect_rising_reg;
        cmd.width          = in_word.capture_value - last_capture_reg;
        cmd.button_first   = in_word.button_first;
        cmd.button_second  = in_word.button_second;
        cmd.left_ir_level  = in_word.left_ir_level;
        cmd.right_ir_level = in_word.right_ir_level;
    end

    // edge tracking state
    always_comb
    begin
        expect_rising_next = expect_rising_reg;
        last_capture_next  = last_capture_reg;
        if (cmd_push && is_capture)
        begin
            expect_rising_next = !expect_rising_reg;
            last_capture_next  = in_word.capture_value;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_rising_reg <= 1'b1;
            last_capture_reg  <= '0;
        end
        else
        begin
            expect_rising_reg <= expect_rising_next;
            last_capture_reg  <= last_capture_next;
        end
    end

endmodule

// File: src/erfs_back.sv
// back end: distance scaling, run mode and motor steering, plus config registers
`include "assert_macros.svh"

module erfs_back #(
    parameter int TICKS_PER_CM = 116
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_write_en,
    input  logic [erfs_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [erfs_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  erfs_pkg::cmd_t                      cmd,
    input  logic                                cmd_empty,
    output logic                                cmd_pop,
    input  logic                                out_full,
    output logic                                out_push,
    output erfs_pkg::out_word_t                 out_word
);

    // width / TICKS_PER_CM as a multiply by a rounded-up reciprocal
    localparam int SHIFT = 16 + $clog2(TICKS_PER_CM);
    localparam longint unsigned RECIP_FULL =
        ((64'd1 << SHIFT) + TICKS_PER_CM - 1) / TICKS_PER_CM;
    localparam logic [17:0] RECIP = 18'(RECIP_FULL);

    logic [7:0] forward_duty_reg, turn_fast_duty_reg, turn_slow_duty_reg;
    logic [9:0] follow_near_cm_reg, follow_far_cm_reg, backoff_cm_reg;

    logic       run_mode_reg, run_mode_next;
    logic [9:0] measured_cm_reg, measured_cm_next;
    logic       left_dir_reg, left_dir_next;
    logic       right_dir_reg, right_dir_next;
    logic [7:0] left_duty_reg, left_duty_next;
    logic [7:0] right_duty_reg, right_duty_next;

    logic [33:0] product;
    logic [15:0] quotient;
    logic [9:0]  cm_sat;
    logic        left_seen, right_seen, in_window;

    assign cmd_pop  = !cmd_empty && !out_full;
    assign out_push = cmd_pop;

    // distance from pulse width
    assign product  = 34'(cmd.width) * 34'(RECIP);
    assign quotient = 16'(product >> SHIFT);
    assign cm_sat   = (quotient > 16'(erfs_pkg::CM_MAX)) ? erfs_pkg::CM_MAX : quotient[9:0];

    // steering conditions, ir low means object seen
    assign left_seen  = !cmd.left_ir_level;
    assign right_seen = !cmd.right_ir_level;
    assign in_window  = (measured_cm_reg > follow_near_cm_reg)
                     && (measured_cm_reg < follow_far_cm_reg);

    always_comb
    begin
        run_mode_next    = run_mode_reg;
        measured_cm_next = measured_cm_reg;
        left_dir_next    = left_dir_reg;
        right_dir_next   = right_dir_reg;
        left_duty_next   = left_duty_reg;
        right_duty_next  = right_duty_reg;
        if (cmd_pop)
        begin
            if (cmd.operation == erfs_pkg::OP_CAPTURE)
            begin
                if (cmd.measure)
                begin
                    measured_cm_next = cm_sat;
                end
            end
            else
            begin
                run_mode_next = run_mode_reg ^ (cmd.button_first && cmd.button_second);
                if (!run_mode_next)
                begin
                    left_duty_next  = '0;
                    right_duty_next = '0;
                end
                else if (left_seen && right_seen && in_window)
                begin
                    left_dir_next   = erfs_pkg::LEFT_FWD;
                    right_dir_next  = erfs_pkg::RIGHT_FWD;
                    left_duty_next  = forward_duty_reg;
                    right_duty_next = forward_duty_reg;
                end
                else if (right_seen && !left_seen)
                begin
                    left_dir_next   = erfs_pkg::LEFT_FWD;
                    right_dir_next  = erfs_pkg::RIGHT_FWD;
                    left_duty_next  = turn_fast_duty_reg;
                    right_duty_next = turn_slow_duty_reg;
                end
                else if (left_seen && !right_seen)
                begin
                    left_dir_next   = erfs_pkg::LEFT_FWD;
                    right_dir_next  = erfs_pkg::RIGHT_FWD;
                    left_duty_next  = turn_slow_duty_reg;
                    right_duty_next = turn_fast_duty_reg;
                end
                else if (measured_cm_reg < backoff_cm_reg)
                begin
                    left_dir_next   = erfs_pkg::LEFT_BWD;
                    right_dir_next  = erfs_pkg::RIGHT_BWD;
                    left_duty_next  = forward_duty_reg;
                    right_duty_next = forward_duty_reg;
                end
                else
                begin
                    left_dir_next   = erfs_pkg::LEFT_FWD;
                    right_dir_next  = erfs_pkg::RIGHT_FWD;
                    left_duty_next  = '0;
                    right_duty_next = '0;
                end
            end
        end
    end

    // result word shows the state after the item
    always_comb
    begin
        out_word.left_dir_level  = left_dir_next;
        out_word.right_dir_level = right_dir_next;
        out_word.left_duty       = left_duty_next;
        out_word.right_duty      = right_duty_next;
        out_word.distance_cm     = measured_cm_next;
        out_word.running         = run_mode_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_mode_reg    <= 1'b0;
            measured_cm_reg <= '0;
            left_dir_reg    <= 1'b0;
            right_dir_reg   <= 1'b0;
            left_duty_reg   <= '0;
            right_duty_reg  <= '0;
        end
        else
        begin
            run_mode_reg    <= run_mode_next;
            measured_cm_reg <= measured_cm_next;
            left_dir_reg    <= left_dir_next;
            right_dir_reg   <= right_dir_next;
            left_duty_reg   <= left_duty_next;
            right_duty_reg  <= right_duty_next;
        end
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            forward_duty_reg   <= erfs_pkg::FORWARD_DUTY_RST;
            turn_fast_duty_reg <= erfs_pkg::TURN_FAST_DUTY_RST;
            turn_slow_duty_reg <= erfs_pkg::TURN_SLOW_DUTY_RST;
            follow_near_cm_reg <= erfs_pkg::FOLLOW_NEAR_CM_RST;
            follow_far_cm_reg  <= erfs_pkg::FOLLOW_FAR_CM_RST;
            backoff_cm_reg     <= erfs_pkg::BACKOFF_CM_RST;
        end
        else if (cfg_write_en)
        begin
            case (cfg_index)
                erfs_pkg::REG_FORWARD_DUTY:   forward_duty_reg   <= cfg_data[7:0];
                erfs_pkg::REG_TURN_FAST_DUTY: turn_fast_duty_reg <= cfg_data[7:0];
                erfs_pkg::REG_TURN_SLOW_DUTY: turn_slow_duty_reg <= cfg_data[7:0];
                erfs_pkg::REG_FOLLOW_NEAR_CM: follow_near_cm_reg <= cfg_data;
                erfs_pkg::REG_FOLLOW_FAR_CM:  follow_far_cm_reg  <= cfg_data;
                erfs_pkg::REG_BACKOFF_CM:     backoff_cm_reg     <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    `ERFS_ASSERT_NEVER(a_push_into_full, out_push && out_full, "result pushed into full queue")
    `ERFS_ASSERT(a_tick_keeps_distance, cmd_pop && cmd.operation == erfs_pkg::OP_TICK |=> measured_cm_reg == $past(measured_cm_reg), "tick changed distance")
    `ERFS_ASSERT(a_capture_keeps_motors, cmd_pop && cmd.operation == erfs_pkg::OP_CAPTURE |=> run_mode_reg == $past(run_mode_reg) && left_duty_reg == $past(left_duty_reg) && right_duty_reg == $past(right_duty_reg), "capture changed motor state")

endmodule

// File: src/echo_ranging_follow_steering.sv
// top level of the echo ranging and follow steering block
//
// Input side is a queue: drive in_word and raise push; the word is taken at a
// clock edge where push is high and full is low. A word is either an echo
// capture (timer value at an echo edge, edges alternate rising then falling)
// or a control tick (double-sampled button and two IR levels).
// Result side is a queue: while empty is low, out_word holds the oldest
// result; it is taken at an edge where pop is high. Every input word makes
// exactly one result word holding directions, duties, distance and run mode.
// A taken word is registered in the command queue, and its result then in the result queue.
// Throughput: one word per cycle while the receiver keeps popping; the back end
// does one reciprocal multiply for the distance, then the steering priority.
// Short command and result queues decouple the sides: when the receiver stops
// popping, the result queue fills, then the command queue, then full rises.
// Configuration: cfg_write_en, cfg_index, cfg_data write one register per
// cycle; write only while the block is idle. Unknown indexes are ignored.
// Reset (rst_n low, asynchronous) empties both queues, restores register
// defaults, stops run mode, zeroes distance and motor outputs and waits for a
// rising echo edge.
module echo_ranging_follow_steering #(
    parameter int TICKS_PER_CM = 116,
    parameter int QUEUE_DEPTH  = 2
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  erfs_pkg::in_word_t               in_word,
    output logic                             full,
    input  logic                             pop,
    output erfs_pkg::out_word_t              out_word,
    output logic                             empty,
    input  logic                             cfg_write_en,
    input  logic [erfs_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [erfs_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int CMD_W = $bits(erfs_pkg::cmd_t);
    localparam int OUT_W = $bits(erfs_pkg::out_word_t);

    erfs_pkg::cmd_t      front_cmd, back_cmd;
    erfs_pkg::out_word_t back_word;
    logic                front_push, cmd_full, cmd_empty, cmd_pop;
    logic                res_push, res_full;

    // front end
    erfs_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .in_word  (in_word),
        .cmd_full (cmd_full),
        .cmd_push (front_push),
        .cmd      (front_cmd)
    );

    assign full = cmd_full;

    // command queue between front and back
    erfs_fifo #(
        .W     (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (front_push),
        .din   (front_cmd),
        .full  (cmd_full),
        .pop   (cmd_pop),
        .dout  (back_cmd),
        .empty (cmd_empty)
    );

    // back end
    erfs_back #(
        .TICKS_PER_CM (TICKS_PER_CM)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write_en (cfg_write_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .cmd          (back_cmd),
        .cmd_empty    (cmd_empty),
        .cmd_pop      (cmd_pop),
        .out_full     (res_full),
        .out_push     (res_push),
        .out_word     (back_word)
    );

    // result queue
    erfs_fifo #(
        .W     (OUT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .din   (back_word),
        .full  (res_full),
        .pop   (pop),
        .dout  (out_word),
        .empty (empty)
    );

endmodule
